@@ hw/rtl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg - shared types for the primitive pair collision test
// Pair kind codes and the control word that travels along the pipelines.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // pair kind carried with each request
  typedef enum logic [1:0] {
    ACT_SPH_SPH = 2'd0,
    ACT_BOX_BOX = 2'd1,
    ACT_SPH_BOX = 2'd2,
    ACT_BOX_SPH = 2'd3
  } act_t;

  // control word moving with the data through the arithmetic pipelines
  typedef struct packed {
    logic valid;
    logic zero;   // divisor is zero, force a zero quotient
  } ctl_t;

endpackage

@@ hw/rtl/primitive_pair_collision_test_top.sv @@
// ----------------------------------------------------------------------------
// primitive_pair_collision_test_top - sphere / box pair intersection test
// Hit flag and one closest point per body for a sphere or box pair.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises, so
// one pair per clock is sustained. Each result appears on the out_ ports
// marked by a one-cycle out_valid strobe, in request order. The pipeline
// passes through the bit-serial square root of the centre distance
// (COORD_BITS+1 stages) and the restoring divider that scales the push-out
// direction (COORD_BITS-1 stages), with one stage between them that forms
// the rounded numerators; four stages of difference, clamp, square and sum
// come before them and one of saturation and selection after.
module primitive_pair_collision_test_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [3*COORD_BITS-1:0]   in_first_center,
  input  logic [COORD_BITS-2:0]     in_first_radius,
  input  logic [3*COORD_BITS-1:0]   in_first_min,
  input  logic [3*COORD_BITS-1:0]   in_first_max,
  input  logic [3*COORD_BITS-1:0]   in_second_center,
  input  logic [COORD_BITS-2:0]     in_second_radius,
  input  logic [3*COORD_BITS-1:0]   in_second_min,
  input  logic [3*COORD_BITS-1:0]   in_second_max,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic [3*COORD_BITS-1:0]   out_first_closest,
  output logic [3*COORD_BITS-1:0]   out_second_closest
);

  localparam int CB   = COORD_BITS;
  localparam int RW   = CB - 1;
  localparam int SQW  = 2 * CB;
  localparam int DW   = 2 * CB + 2;
  localparam int SW   = DW / 2;
  localparam int PW   = 2 * CB - 1;
  localparam int NW   = 2 * CB + 1;
  localparam int DENW = SW + 1;
  localparam int QW   = CB - 1;
  localparam int SLAT = SW + QW + 2;

  typedef logic [2:0][CB-1:0] vec_t;

  typedef struct packed {
    pcc_pkg::act_t act;
    logic          hit;
    vec_t          c1;
    vec_t          c2;
    vec_t          p1c;
    vec_t          p2c;
    logic [2:0]    neg;
  } side_t;

  typedef struct packed {
    logic [2:0][PW-1:0] pm1;
    logic [2:0][PW-1:0] pm2;
  } prod_t;

  function automatic logic [CB-1:0] clamp(input logic [CB-1:0] v, input logic [CB-1:0] lo,
                                          input logic [CB-1:0] hi);
    logic [CB-1:0] t;
    t = ($signed(v) < $signed(lo)) ? lo : v;
    if ($signed(t) > $signed(hi)) t = hi;
    return t;
  endfunction

  function automatic logic [CB-1:0] sat(input logic [CB:0] v);
    logic [CB-1:0] t;
    t = v[CB-1:0];
    if (v[CB] != v[CB-1]) t = v[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    return t;
  endfunction

  // the receiver never stalls, so requests are always taken
  assign busy = 1'b0;

  vec_t c1, c2, lo1, hi1, lo2, hi2;
  pcc_pkg::act_t act_in;
  assign c1     = in_first_center;
  assign c2     = in_second_center;
  assign lo1    = in_first_min;
  assign hi1    = in_first_max;
  assign lo2    = in_second_min;
  assign hi2    = in_second_max;
  assign act_in = pcc_pkg::act_t'(in_action);

  // stage a: differences, clamps, box overlap, radius sum or single radius
  logic               a_v_r, a_ov_r, a_ov_nxt;
  pcc_pkg::act_t      a_act_r;
  vec_t               a_c1_r, a_c2_r, a_p1c_r, a_p2c_r, a_p1c_nxt, a_p2c_nxt;
  logic [2:0][CB:0]   a_d_r, a_d_nxt;
  logic [CB-1:0]      a_rr_r, a_rr_nxt;
  logic [RW-1:0]      a_r1_r, a_r2_r;

  always_comb begin
    a_ov_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      a_d_nxt[i]   = {c1[i][CB-1], c1[i]} - {c2[i][CB-1], c2[i]};
      a_p1c_nxt[i] = clamp(c1[i], lo2[i], hi2[i]);
      a_p2c_nxt[i] = clamp(c2[i], lo1[i], hi1[i]);
      if (!($signed(lo1[i]) < $signed(hi2[i]) && $signed(hi1[i]) > $signed(lo2[i])))
        a_ov_nxt = 1'b0;
    end
    unique case (act_in)
      pcc_pkg::ACT_SPH_SPH: a_rr_nxt = {1'b0, in_first_radius} + {1'b0, in_second_radius};
      pcc_pkg::ACT_BOX_BOX: a_rr_nxt = '0;
      pcc_pkg::ACT_SPH_BOX: a_rr_nxt = {1'b0, in_first_radius};
      pcc_pkg::ACT_BOX_SPH: a_rr_nxt = {1'b0, in_second_radius};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= start && !busy;
    end
    a_act_r <= act_in;
    a_c1_r  <= c1;
    a_c2_r  <= c2;
    a_p1c_r <= a_p1c_nxt;
    a_p2c_r <= a_p2c_nxt;
    a_d_r   <= a_d_nxt;
    a_ov_r  <= a_ov_nxt;
    a_rr_r  <= a_rr_nxt;
    a_r1_r  <= in_first_radius;
    a_r2_r  <= in_second_radius;
  end

  // stage b: squared differences, clamp offsets, magnitudes, squared radius term
  logic                b_v_r, b_ov_r;
  pcc_pkg::act_t       b_act_r;
  vec_t                b_c1_r, b_c2_r, b_p1c_r, b_p2c_r;
  logic [2:0][SQW-1:0] b_dsq_r, b_dsq_nxt;
  logic [2:0][CB:0]    b_e_r, b_e_nxt;
  logic [2:0][CB-1:0]  b_mag_r, b_mag_nxt;
  logic [2:0]          b_neg_r;
  logic [SQW-1:0]      b_rrsq_r;
  logic [RW-1:0]       b_r1_r, b_r2_r;

  always_comb begin
    logic signed [SQW+1:0] sq;
    logic [CB:0]           ab;
    for (int i = 0; i < 3; i++) begin
      sq           = $signed(a_d_r[i]) * $signed(a_d_r[i]);
      b_dsq_nxt[i] = sq[SQW-1:0];
      ab           = a_d_r[i][CB] ? -a_d_r[i] : a_d_r[i];
      b_mag_nxt[i] = ab[CB-1:0];
      if (a_act_r == pcc_pkg::ACT_SPH_BOX)
        b_e_nxt[i] = {a_c1_r[i][CB-1], a_c1_r[i]} - {a_p1c_r[i][CB-1], a_p1c_r[i]};
      else
        b_e_nxt[i] = {a_c2_r[i][CB-1], a_c2_r[i]} - {a_p2c_r[i][CB-1], a_p2c_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
    b_act_r  <= a_act_r;
    b_ov_r   <= a_ov_r;
    b_c1_r   <= a_c1_r;
    b_c2_r   <= a_c2_r;
    b_p1c_r  <= a_p1c_r;
    b_p2c_r  <= a_p2c_r;
    b_dsq_r  <= b_dsq_nxt;
    b_e_r    <= b_e_nxt;
    b_mag_r  <= b_mag_nxt;
    for (int i = 0; i < 3; i++) b_neg_r[i] <= a_d_r[i][CB];
    b_rrsq_r <= SQW'(a_rr_r) * SQW'(a_rr_r);
    b_r1_r   <= a_r1_r;
    b_r2_r   <= a_r2_r;
  end

  // stage c: centre distance sum, offset squares, radius products
  logic                c_v_r, c_ov_r;
  pcc_pkg::act_t       c_act_r;
  vec_t                c_c1_r, c_c2_r, c_p1c_r, c_p2c_r;
  logic [2:0]          c_neg_r;
  logic [SQW-1:0]      c_rrsq_r;
  logic [DW-1:0]       c_dd_r;
  logic [2:0][SQW-1:0] c_esq_r, c_esq_nxt;
  logic [2:0][PW-1:0]  c_pm1_r, c_pm2_r, c_pm1_nxt, c_pm2_nxt;

  always_comb begin
    logic signed [SQW+1:0] sq;
    for (int i = 0; i < 3; i++) begin
      sq           = $signed(b_e_r[i]) * $signed(b_e_r[i]);
      c_esq_nxt[i] = sq[SQW-1:0];
      c_pm1_nxt[i] = PW'(b_mag_r[i]) * PW'(b_r2_r);
      c_pm2_nxt[i] = PW'(b_mag_r[i]) * PW'(b_r1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
    c_act_r  <= b_act_r;
    c_ov_r   <= b_ov_r;
    c_c1_r   <= b_c1_r;
    c_c2_r   <= b_c2_r;
    c_p1c_r  <= b_p1c_r;
    c_p2c_r  <= b_p2c_r;
    c_neg_r  <= b_neg_r;
    c_rrsq_r <= b_rrsq_r;
    c_dd_r   <= DW'(b_dsq_r[0]) + DW'(b_dsq_r[1]) + DW'(b_dsq_r[2]);
    c_esq_r  <= c_esq_nxt;
    c_pm1_r  <= c_pm1_nxt;
    c_pm2_r  <= c_pm2_nxt;
  end

  // stage d: hit decision, side data enters the delay lines
  logic          d_v_r;
  logic [DW-1:0] d_dd_r;
  side_t         side_nxt;
  side_t         sd_r [SLAT];
  prod_t         pd_r [SW+1];

  always_comb begin
    logic [DW-1:0] ee;
    ee           = DW'(c_esq_r[0]) + DW'(c_esq_r[1]) + DW'(c_esq_r[2]);
    side_nxt.act = c_act_r;
    side_nxt.c1  = c_c1_r;
    side_nxt.c2  = c_c2_r;
    side_nxt.p1c = c_p1c_r;
    side_nxt.p2c = c_p2c_r;
    side_nxt.neg = c_neg_r;
    unique case (c_act_r)
      pcc_pkg::ACT_SPH_SPH: side_nxt.hit = c_dd_r < DW'(c_rrsq_r);
      pcc_pkg::ACT_BOX_BOX: side_nxt.hit = c_ov_r;
      pcc_pkg::ACT_SPH_BOX,
      pcc_pkg::ACT_BOX_SPH: side_nxt.hit = ee < DW'(c_rrsq_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else begin
      d_v_r <= c_v_r;
    end
    d_dd_r    <= c_dd_r;
    sd_r[0]   <= side_nxt;
    pd_r[0]   <= '{pm1: c_pm1_r, pm2: c_pm2_r};
    for (int k = 1; k < SLAT; k++) sd_r[k] <= sd_r[k-1];
    for (int k = 1; k <= SW; k++) pd_r[k] <= pd_r[k-1];
  end

  // distance length
  pcc_pkg::ctl_t sq_ctl;
  logic [SW-1:0] sq_root;

  pcc_isqrt #(
    .IN_W (DW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   ('{valid: d_v_r, zero: 1'b0}),
    .in_rad   (d_dd_r),
    .out_ctl  (sq_ctl),
    .out_root (sq_root)
  );

  // stage n: rounded numerators and divisor
  pcc_pkg::ctl_t      n_ctl_r;
  logic [5:0][NW-1:0] n_num_r, n_num_nxt;
  logic [DENW-1:0]    n_den_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_num_nxt[i]   = NW'({pd_r[SW].pm1[i], 1'b0}) + NW'(sq_root);
      n_num_nxt[i+3] = NW'({pd_r[SW].pm2[i], 1'b0}) + NW'(sq_root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_ctl_r <= '0;
    end else begin
      n_ctl_r <= '{valid: sq_ctl.valid, zero: (sq_root == '0)};
    end
    n_num_r <= n_num_nxt;
    n_den_r <= {sq_root, 1'b0};
  end

  // scaled direction components
  pcc_pkg::ctl_t      dv_ctl;
  logic [5:0][QW-1:0] dv_q;

  pcc_div #(
    .LANES (6),
    .NUM_W (NW),
    .DEN_W (DENW),
    .Q_W   (QW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (n_ctl_r),
    .in_num  (n_num_r),
    .in_den  (n_den_r),
    .out_ctl (dv_ctl),
    .out_q   (dv_q)
  );

  // output stage: push-out, saturation, selection by pair kind
  side_t          s_last;
  vec_t           push1, push2, p1_nxt, p2_nxt;
  logic           out_valid_r, out_hit_r;
  logic [3*CB-1:0] out_p1_r, out_p2_r;

  assign s_last = sd_r[SLAT-1];

  always_comb begin
    logic [CB:0] qa, qb;
    for (int i = 0; i < 3; i++) begin
      qa       = {2'b00, dv_q[i]};
      qb       = {2'b00, dv_q[i+3]};
      push1[i] = sat({s_last.c1[i][CB-1], s_last.c1[i]} + (s_last.neg[i] ? -qa : qa));
      push2[i] = sat({s_last.c2[i][CB-1], s_last.c2[i]} + (s_last.neg[i] ? qb : -qb));
    end
    p1_nxt = (s_last.act == pcc_pkg::ACT_SPH_SPH || s_last.act == pcc_pkg::ACT_BOX_SPH)
             ? push1 : s_last.p1c;
    p2_nxt = (s_last.act == pcc_pkg::ACT_SPH_SPH || s_last.act == pcc_pkg::ACT_SPH_BOX)
             ? push2 : s_last.p2c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_ctl.valid;
    end
    out_hit_r <= s_last.hit;
    out_p1_r  <= p1_nxt;
    out_p2_r  <= p2_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_first_closest  = out_p1_r;
  assign out_second_closest = out_p2_r;

  // checks
  a_req_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> a_v_r)
    else $error("accepted request did not enter the pipeline");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    sq_ctl.valid |=> n_ctl_r.valid && (n_ctl_r.zero == (n_den_r == '0)))
    else $error("zero divisor flag out of step with divisor");

  a_out_follows_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dv_ctl.valid))
    else $error("result strobe without a divider result");

endmodule

@@ hw/rtl/pcc_isqrt.sv @@
// ----------------------------------------------------------------------------
// pcc_isqrt - pipelined integer square root
// One result bit per register stage, floor(sqrt(in_rad)), IN_W/2 stages.
// ----------------------------------------------------------------------------
module pcc_isqrt #(
  parameter int IN_W = 34
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcc_pkg::ctl_t       in_ctl,
  input  logic [IN_W-1:0]     in_rad,
  output pcc_pkg::ctl_t       out_ctl,
  output logic [IN_W/2-1:0]   out_root
);

  localparam int STEPS = IN_W / 2;

  logic [IN_W-1:0] rem_r   [STEPS];
  logic [IN_W-1:0] res_r   [STEPS];
  pcc_pkg::ctl_t   ctl_r   [STEPS];
  logic [IN_W-1:0] rem_in  [STEPS];
  logic [IN_W-1:0] res_in  [STEPS];
  pcc_pkg::ctl_t   ctl_in  [STEPS];
  logic [IN_W-1:0] rem_nxt [STEPS];
  logic [IN_W-1:0] res_nxt [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * g);

    // stage input, first stage from the ports
    if (g == 0) begin : g_first
      assign rem_in[g] = in_rad;
      assign res_in[g] = '0;
      assign ctl_in[g] = in_ctl;
    end else begin : g_next
      assign rem_in[g] = rem_r[g-1];
      assign res_in[g] = res_r[g-1];
      assign ctl_in[g] = ctl_r[g-1];
    end

    // one trial subtraction
    always_comb begin
      logic [IN_W-1:0] trial;
      trial = res_in[g] + BIT;
      if (rem_in[g] >= trial) begin
        rem_nxt[g] = rem_in[g] - trial;
        res_nxt[g] = (res_in[g] >> 1) + BIT;
      end else begin
        rem_nxt[g] = rem_in[g];
        res_nxt[g] = res_in[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else begin
        ctl_r[g] <= ctl_in[g];
      end
      rem_r[g] <= rem_nxt[g];
      res_r[g] <= res_nxt[g];
    end
  end

  assign out_ctl  = ctl_r[STEPS-1];
  assign out_root = res_r[STEPS-1][STEPS-1:0];

endmodule

@@ hw/rtl/pcc_div.sv @@
// ----------------------------------------------------------------------------
// pcc_div - pipelined restoring divider, several lanes over one divisor
// One quotient bit per register stage; quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module pcc_div #(
  parameter int LANES = 6,
  parameter int NUM_W = 33,
  parameter int DEN_W = 18,
  parameter int Q_W   = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcc_pkg::ctl_t                in_ctl,
  input  logic [LANES-1:0][NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]             in_den,
  output pcc_pkg::ctl_t                out_ctl,
  output logic [LANES-1:0][Q_W-1:0]    out_q
);

  logic [LANES-1:0][NUM_W-1:0] rem_r   [Q_W];
  logic [LANES-1:0][Q_W-1:0]   q_r     [Q_W];
  logic [DEN_W-1:0]            den_r   [Q_W];
  pcc_pkg::ctl_t               ctl_r   [Q_W];
  logic [LANES-1:0][NUM_W-1:0] rem_in  [Q_W];
  logic [LANES-1:0][Q_W-1:0]   q_in    [Q_W];
  logic [DEN_W-1:0]            den_in  [Q_W];
  pcc_pkg::ctl_t               ctl_in  [Q_W];
  logic [LANES-1:0][NUM_W-1:0] rem_nxt [Q_W];
  logic [LANES-1:0][Q_W-1:0]   q_nxt   [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_step
    localparam int SH = Q_W - 1 - g;

    if (g == 0) begin : g_first
      assign rem_in[g] = in_num;
      assign q_in[g]   = '0;
      assign den_in[g] = in_den;
      assign ctl_in[g] = in_ctl;
    end else begin : g_next
      assign rem_in[g] = rem_r[g-1];
      assign q_in[g]   = q_r[g-1];
      assign den_in[g] = den_r[g-1];
      assign ctl_in[g] = ctl_r[g-1];
    end

    // trial subtract of the shifted divisor in every lane
    always_comb begin
      logic [NUM_W-1:0] sub;
      sub = NUM_W'(den_in[g]) << SH;
      rem_nxt[g] = rem_in[g];
      q_nxt[g]   = q_in[g];
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[g][l] >= sub) begin
          rem_nxt[g][l]   = rem_in[g][l] - sub;
          q_nxt[g][l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else begin
        ctl_r[g] <= ctl_in[g];
      end
      rem_r[g] <= rem_nxt[g];
      q_r[g]   <= q_nxt[g];
      den_r[g] <= den_in[g];
    end
  end

  // the zero flag forces a zero quotient
  assign out_ctl = ctl_r[Q_W-1];
  assign out_q   = ctl_r[Q_W-1].zero ? '0 : q_r[Q_W-1];

endmodule

@@ tb/sv/pcc_checker.sv @@
// ----------------------------------------------------------------------------
// pcc_checker - result predictor and scoreboard for the pair collision test
// Watches accepted requests, predicts hit flag and closest points, and
// compares every out_valid strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module pcc_checker #(
  parameter int CB = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  logic [1:0]      in_action,
  input  logic [3*CB-1:0] in_first_center,
  input  logic [CB-2:0]   in_first_radius,
  input  logic [3*CB-1:0] in_first_min,
  input  logic [3*CB-1:0] in_first_max,
  input  logic [3*CB-1:0] in_second_center,
  input  logic [CB-2:0]   in_second_radius,
  input  logic [3*CB-1:0] in_second_min,
  input  logic [3*CB-1:0] in_second_max,
  input  logic            out_valid,
  input  logic            out_hit,
  input  logic [3*CB-1:0] out_first_closest,
  input  logic [3*CB-1:0] out_second_closest,
  output int              fail_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef longint pt_t [3];

  typedef struct packed {
    logic            hit;
    logic [3*CB-1:0] first_pt;
    logic [3*CB-1:0] second_pt;
  } contact_t;

  contact_t contact_q [$];

  function automatic void unpack_pt(input logic [3*CB-1:0] v, output pt_t p);
    for (int i = 0; i < 3; i++) p[i] = longint'($signed(v[i*CB +: CB]));
  endfunction

  function automatic logic [3*CB-1:0] pack_pt(input pt_t p);
    logic [3*CB-1:0] v;
    for (int i = 0; i < 3; i++) v[i*CB +: CB] = p[i][CB-1:0];
    return v;
  endfunction

  function automatic longint unsigned sq_dist(input pt_t a, input pt_t b);
    longint unsigned s;
    longint d;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d = a[i] - b[i];
      s += longint'(d * d);
    end
    return s;
  endfunction

  function automatic longint unsigned isqrt_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // base moved by r along the direction away from the other centre
  function automatic void push_away(input pt_t base, input pt_t away,
                                    input longint unsigned r, output pt_t p);
    longint unsigned len, mag, q;
    longint d, off, v;
    len = isqrt_floor(sq_dist(base, away));
    for (int i = 0; i < 3; i++) begin
      d = base[i] - away[i];
      off = 0;
      if (len != 0) begin
        mag = (d < 0) ? -d : d;
        q = (mag * r * 2 + len) / (2 * len);
        off = (d < 0) ? -longint'(q) : longint'(q);
      end
      v = base[i] + off;
      p[i] = (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
    end
  endfunction

  // min corner first, then max corner, so max wins on an inverted axis
  function automatic void clamp_into_box(input pt_t c, input pt_t lo, input pt_t hi,
                                         output pt_t p);
    for (int i = 0; i < 3; i++) begin
      p[i] = c[i];
      if (p[i] < lo[i]) p[i] = lo[i];
      if (p[i] > hi[i]) p[i] = hi[i];
    end
  endfunction

  function automatic contact_t predict_contact();
    pcc_pkg::act_t act;
    pt_t c1, lo1, hi1, c2, lo2, hi2, p1, p2;
    longint unsigned r1, r2;
    contact_t res;
    act = pcc_pkg::act_t'(in_action);
    unpack_pt(in_first_center, c1);
    unpack_pt(in_first_min, lo1);
    unpack_pt(in_first_max, hi1);
    unpack_pt(in_second_center, c2);
    unpack_pt(in_second_min, lo2);
    unpack_pt(in_second_max, hi2);
    r1 = in_first_radius;
    r2 = in_second_radius;
    case (act)
      pcc_pkg::ACT_SPH_SPH: begin
        push_away(c1, c2, r2, p1);
        push_away(c2, c1, r1, p2);
        res.hit = sq_dist(c1, c2) < (r1 + r2) * (r1 + r2);
      end
      pcc_pkg::ACT_BOX_BOX: begin
        clamp_into_box(c1, lo2, hi2, p1);
        clamp_into_box(c2, lo1, hi1, p2);
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++)
          if (!(lo1[i] < hi2[i] && hi1[i] > lo2[i])) res.hit = 1'b0;
      end
      pcc_pkg::ACT_SPH_BOX: begin
        clamp_into_box(c1, lo2, hi2, p1);
        push_away(c2, c1, r1, p2);
        res.hit = sq_dist(c1, p1) < r1 * r1;
      end
      default: begin
        clamp_into_box(c2, lo1, hi1, p2);
        push_away(c1, c2, r2, p1);
        res.hit = sq_dist(c2, p2) < r2 * r2;
      end
    endcase
    res.first_pt = pack_pt(p1);
    res.second_pt = pack_pt(p2);
    return res;
  endfunction

  assign pending = contact_q.size();

  // predict on each accepted request, compare on each result strobe
  always @(posedge clk) begin
    contact_t exp_c;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) contact_q.push_back(predict_contact());
      if (out_valid) begin
        if (contact_q.size() == 0) begin
          if (fail_count < 10) $display("%0t: result with no request waiting", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = contact_q.pop_front();
          if (exp_c.hit !== out_hit || exp_c.first_pt !== out_first_closest ||
              exp_c.second_pt !== out_second_closest) begin
            if (fail_count < 10)
              $display("%0t: mismatch hit %b/%b first %h/%h second %h/%h (exp/act)",
                       $realtime, exp_c.hit, out_hit, exp_c.first_pt,
                       out_first_closest, exp_c.second_pt, out_second_closest);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the primitive pair collision test
// Drives directed corner pairs then random sphere / box pairs with random
// gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int LATENCY = 2 * CB + 6;
  localparam int N_RANDOM = 850;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [1:0]      in_action = '0;
  logic [3*CB-1:0] in_first_center = '0, in_first_min = '0, in_first_max = '0;
  logic [3*CB-1:0] in_second_center = '0, in_second_min = '0, in_second_max = '0;
  logic [CB-2:0]   in_first_radius = '0, in_second_radius = '0;
  logic            out_valid, out_hit;
  logic [3*CB-1:0] out_first_closest, out_second_closest;
  int              fail_count, pending;

  always #10 clk = ~clk;

  primitive_pair_collision_test_top #(.COORD_BITS(CB)) dut (.*);

  pcc_checker #(.CB(CB)) u_checker (.*);

  typedef struct {
    pcc_pkg::act_t   act;
    logic [3*CB-1:0] c1, lo1, hi1, c2, lo2, hi2;
    logic [CB-2:0]   r1, r2;
  } pair_req_t;

  pair_req_t dir_q [$];
  bit        no_gaps;

  // send one request, then hold off for a random gap unless no_gaps is set
  task automatic send_pair(input pair_req_t p);
    int gap;
    start            <= 1'b1;
    in_action        <= p.act;
    in_first_center  <= p.c1;
    in_first_radius  <= p.r1;
    in_first_min     <= p.lo1;
    in_first_max     <= p.hi1;
    in_second_center <= p.c2;
    in_second_radius <= p.r2;
    in_second_min    <= p.lo2;
    in_second_max    <= p.hi2;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    gap = no_gaps ? 0 : $urandom_range(18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // coordinate: mostly near the origin so bodies meet, sometimes anywhere
  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return {1'b0, {(CB-1){1'b1}}};
      1:       return {1'b1, {(CB-1){1'b0}}};
      2, 3:    return CB'($urandom());
      default: return CB'($urandom_range(2400) - 1200);
    endcase
  endfunction

  function automatic logic [3*CB-1:0] rand_pt();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [CB-2:0] rand_radius();
    return ($urandom_range(4) == 0) ? (CB-1)'($urandom()) : (CB-1)'($urandom_range(1500));
  endfunction

  // box around a centre; occasionally inverted or fully random
  task automatic rand_box(input logic [3*CB-1:0] c, output logic [3*CB-1:0] lo,
                          output logic [3*CB-1:0] hi);
    int v, a, b;
    if ($urandom_range(7) == 0) begin
      lo = rand_pt();
      hi = rand_pt();
    end else begin
      for (int i = 0; i < 3; i++) begin
        v = $signed(c[i*CB +: CB]);
        a = v - int'($urandom_range(800)) + 100;
        b = v + int'($urandom_range(800)) - 100;
        if (a < -32768) a = -32768;
        if (b > 32767) b = 32767;
        lo[i*CB +: CB] = a[CB-1:0];
        hi[i*CB +: CB] = b[CB-1:0];
      end
    end
  endtask

  function automatic pair_req_t mk_pair(pcc_pkg::act_t a, logic [3*CB-1:0] c1,
                                        logic [CB-2:0] r1,
                                        logic [3*CB-1:0] lo1, logic [3*CB-1:0] hi1,
                                        logic [3*CB-1:0] c2, logic [CB-2:0] r2,
                                        logic [3*CB-1:0] lo2, logic [3*CB-1:0] hi2);
    pair_req_t p;
    p.act = a; p.c1 = c1; p.r1 = r1; p.lo1 = lo1; p.hi1 = hi1;
    p.c2 = c2; p.r2 = r2; p.lo2 = lo2; p.hi2 = hi2;
    return p;
  endfunction

  // time limit
  initial begin
    #5ms;
    $display("FAIL primitive_pair_collision_test_top");
    $finish;
  end

  initial begin
    logic [3*CB-1:0] pmax, pmin, one, two;
    pair_req_t       p;
    pmax = {3{16'h7fff}};
    pmin = {3{16'h8000}};
    one  = {16'd0, 16'd0, 16'd256};
    two  = {16'd0, 16'd0, 16'd768};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    no_gaps = 1'b1;
    // coincident centres: zero direction
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_SPH, one, 256, '0, '0, one, 256, '0, '0));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_SPH, '0, 0, '0, '0, '0, 0, '0, '0));
    // exactly touching spheres, then just overlapping
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_SPH, one, 256, '0, '0, two, 256, '0, '0));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_SPH, one, 257, '0, '0, two, 256, '0, '0));
    // extreme centres and radii: saturation
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_SPH, pmax, 15'h7fff, pmin, pmax, pmin,
                            15'h7fff, pmin, pmax));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_BOX, pmin, 15'h7fff, '0, '0, pmax, 15'h7fff,
                            pmin, pmax));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_SPH, pmax, 15'h7fff, pmin, pmax, pmin,
                            15'h7fff, '0, '0));
    // boxes sharing a face: strict test gives no hit
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_BOX, one, 0, '0, one, two, 0, one, two));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_BOX, one, 0, '0, two, two, 0, one, two));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_BOX, pmax, 15'h7fff, pmin, pmax, pmin,
                            15'h7fff, pmin, pmax));
    // inverted boxes
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_BOX, pmin, 0, pmax, pmin, pmax, 0, two, one));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_BOX, pmin, 100, '0, '0, pmax, 100, two, one));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_SPH, '0, 5, two, one, pmin, 300, '0, '0));
    // sphere centre inside the box, and on its surface
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_BOX, one, 0, '0, '0, '0, 0, '0, two));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_SPH_BOX, two, 1, '0, '0, '0, 0, '0, two));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_SPH, '0, 0, '0, one, two, 512, '0, '0));
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_SPH, '0, 0, '0, one, two, 513, '0, '0));
    // all-ones inputs
    dir_q.push_back(mk_pair(pcc_pkg::ACT_BOX_SPH, '1, '1, '1, '1, '1, '1, '1, '1));
    foreach (dir_q[i]) send_pair(dir_q[i]);

    // random pairs, stretches without gaps now and then
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(3) == 0);
      p.act = pcc_pkg::act_t'($urandom_range(3));
      p.c1 = rand_pt();
      p.c2 = ($urandom_range(15) == 0) ? p.c1 : rand_pt();
      p.r1 = rand_radius();
      p.r2 = rand_radius();
      rand_box(p.c1, p.lo1, p.hi1);
      rand_box(p.c2, p.lo2, p.hi2);
      send_pair(p);
    end
    start <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS primitive_pair_collision_test_top");
    end else begin
      $display("FAIL primitive_pair_collision_test_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_isqrt.sv
hw/rtl/pcc_div.sv
hw/rtl/primitive_pair_collision_test_top.sv
tb/sv/pcc_checker.sv
tb/sv/tb_top.sv
